### hdl/b64_pkg.sv
`default_nettype none
package b64_pkg;

	// Input word: one byte or character plus end-of-message mark
	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_t;

	// Output word
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_data;
		logic       out_last;
		logic       stopped_early;
	} out_t;

	// Work handed from the front to the back: one to four output words
	typedef struct packed {
		logic [3:0][7:0] data;     // data[0] goes out first
		logic [2:0]      cnt;      // number of words, 1 to 4
		logic            has_data;
		logic            last;
		logic            stopped;
	} job_t;

	localparam logic        DIR_ENCODE = 1'b0;
	localparam logic        DIR_DECODE = 1'b1;
	localparam logic [7:0]  CHAR_PAD   = 8'h3d;
	localparam logic [7:0]  CHAR_PLUS  = 8'h2b;
	localparam logic [7:0]  CHAR_SLASH = 8'h2f;
	localparam logic [7:0]  CHAR_UA    = 8'h41;
	localparam logic [7:0]  CHAR_UZ    = 8'h5a;
	localparam logic [7:0]  CHAR_LA    = 8'h61;
	localparam logic [7:0]  CHAR_LZ    = 8'h7a;
	localparam logic [7:0]  CHAR_D0    = 8'h30;
	localparam logic [7:0]  CHAR_D9    = 8'h39;

	// Sextet to alphabet character
	function automatic logic [7:0] enc_char(input logic [5:0] s);
		logic [7:0] x;
		x = {2'b00, s};
		if (s < 6'd26)
			return CHAR_UA + x;
		else if (s < 6'd52)
			return CHAR_LA + x - 8'd26;
		else if (s < 6'd62)
			return CHAR_D0 + x - 8'd52;
		else if (s == 6'd62)
			return CHAR_PLUS;
		else
			return CHAR_SLASH;
	endfunction

	// Character to sextet; bit 6 set when the character is in the alphabet
	function automatic logic [6:0] dec_char(input logic [7:0] c);
		logic [7:0] t;
		t = 8'd0;
		if (c >= CHAR_UA && c <= CHAR_UZ) begin
			t = c - CHAR_UA;
			return {1'b1, t[5:0]};
		end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
			t = c - CHAR_LA + 8'd26;
			return {1'b1, t[5:0]};
		end else if (c >= CHAR_D0 && c <= CHAR_D9) begin
			t = c - CHAR_D0 + 8'd52;
			return {1'b1, t[5:0]};
		end else if (c == CHAR_PLUS) begin
			return {1'b1, 6'd62};
		end else if (c == CHAR_SLASH) begin
			return {1'b1, 6'd63};
		end
		return 7'd0;
	endfunction

endpackage
`default_nettype wire

### hdl/b64_front.sv
`default_nettype none
module b64_front (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             cfg_we,
	input  wire             cfg_wdata,
	input  wire             accept,
	input  b64_pkg::in_t    item,
	output logic            push,
	output b64_pkg::job_t   job
);

	logic        dir_q;
	logic [23:0] buf_q;
	logic [1:0]  cnt_q;
	logic        stop_q;

	logic [23:0] buf_n;
	logic [1:0]  cnt_n;
	logic        stop_n;
	logic [23:0] enc_v;
	logic [23:0] dec_v;
	logic [23:0] tail_v;
	logic [6:0]  sx;
	logic [2:0]  cnt1;

	always_comb begin
		buf_n  = buf_q;
		cnt_n  = cnt_q;
		stop_n = stop_q;
		enc_v  = {buf_q[15:0], item.in_byte};
		dec_v  = {buf_q[17:0], 6'd0};
		tail_v = 24'd0;
		sx     = b64_pkg::dec_char(item.in_byte);
		cnt1   = {1'b0, cnt_q} + 3'd1;
		job    = '0;

		if (dir_q == b64_pkg::DIR_ENCODE) begin
			if (cnt_q == 2'd2) begin
				// full group of three bytes
				for (int i = 0; i < 4; i++)
					job.data[i] = b64_pkg::enc_char(enc_v[18 - 6 * i +: 6]);
				job.cnt = 3'd4;
				buf_n   = 24'd0;
				cnt_n   = 2'd0;
			end else if (item.in_last) begin
				// partial group: left-align, then pad with '='
				tail_v = (cnt_q == 2'd0) ? {item.in_byte, 16'd0}
				                         : {buf_q[7:0], item.in_byte, 8'd0};
				for (int i = 0; i < 4; i++) begin
					if (3'(i) <= cnt1)
						job.data[i] = b64_pkg::enc_char(tail_v[18 - 6 * i +: 6]);
					else
						job.data[i] = b64_pkg::CHAR_PAD;
				end
				job.cnt = 3'd4;
			end else begin
				buf_n = enc_v;
				cnt_n = cnt1[1:0];
			end
		end else begin
			if (!stop_q) begin
				if (!sx[6]) begin
					stop_n = 1'b1;
				end else begin
					dec_v = {buf_q[17:0], sx[5:0]};
					if (cnt_q == 2'd3) begin
						job.data[0] = dec_v[23:16];
						job.data[1] = dec_v[15:8];
						job.data[2] = dec_v[7:0];
						job.cnt     = 3'd3;
						buf_n       = 24'd0;
						cnt_n       = 2'd0;
					end else begin
						buf_n = dec_v;
						cnt_n = cnt1[1:0];
					end
				end
			end
			// flush a partial group of two or three characters
			if (item.in_last && cnt_n[1]) begin
				tail_v = cnt_n[0] ? {buf_n[17:0], 6'd0} : {buf_n[11:0], 12'd0};
				job.data[0] = tail_v[23:16];
				job.data[1] = tail_v[15:8];
				job.cnt     = cnt_n[0] ? 3'd2 : 3'd1;
			end
		end

		job.has_data = 1'b1;
		job.stopped  = stop_n;
		job.last     = item.in_last;
		if (item.in_last && job.cnt == 3'd0) begin
			// end marker without data
			job.cnt      = 3'd1;
			job.has_data = 1'b0;
		end
		push = accept && (job.cnt != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= b64_pkg::DIR_ENCODE;
			buf_q  <= 24'd0;
			cnt_q  <= 2'd0;
			stop_q <= 1'b0;
		end else if (cfg_we) begin
			dir_q  <= cfg_wdata;
			buf_q  <= 24'd0;
			cnt_q  <= 2'd0;
			stop_q <= 1'b0;
		end else if (accept) begin
			if (item.in_last) begin
				buf_q  <= 24'd0;
				cnt_q  <= 2'd0;
				stop_q <= 1'b0;
			end else begin
				buf_q  <= buf_n;
				cnt_q  <= cnt_n;
				stop_q <= stop_n;
			end
		end
	end

endmodule
`default_nettype wire

### hdl/b64_queue.sv
`default_nettype none
module b64_queue #(
	parameter int DEPTH = 4
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  b64_pkg::job_t   push_job,
	input  wire             pop,
	output b64_pkg::job_t   head,
	output logic            full,
	output logic            empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b64_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop && !empty)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if ((push && !full) && !(pop && !empty))
				cnt_q <= cnt_q + 1'b1;
			else if (!(push && !full) && (pop && !empty))
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

### hdl/b64_back.sv
`default_nettype none
module b64_back (
	input  wire             clk,
	input  wire             arst_n,
	input  b64_pkg::job_t   head,
	input  wire             empty,
	output logic            pop,
	output b64_pkg::out_t   dout,
	output logic            dout_valid,
	input  wire             dout_stall
);

	logic [1:0]     idx_q;
	logic           vld_q;
	b64_pkg::out_t  out_q;
	logic           load;
	logic           final_w;

	assign load    = !vld_q || !dout_stall;
	assign final_w = ({1'b0, idx_q} == head.cnt - 3'd1);
	assign pop     = load && !empty && final_w;

	assign dout       = out_q;
	assign dout_valid = vld_q;

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			out_q.out_byte      <= head.has_data ? head.data[idx_q] : 8'd0;
			out_q.has_data      <= head.has_data;
			out_q.out_last      <= head.last && final_w;
			out_q.stopped_early <= head.stopped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (load) begin
			vld_q <= !empty;
			if (!empty)
				idx_q <= final_w ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule
`default_nettype wire

### hdl/base64_codec_top.sv
`default_nettype none
// Streaming Base64 codec, standard alphabet with '=' padding.
// Input channel din/din_valid/din_stall carries one byte (encode) or one
// character (decode) per word, with in_last marking the end of a message.
// Output channel dout/dout_valid/dout_stall carries one character or byte
// per word; has_data is low only on the end marker of a message that gives
// no data, out_last marks the final word, stopped_early reports that decode
// met '=' or a non-alphabet character and ignored the rest of the message.
// cfg_we/cfg_wdata write the direction bit (0 encode, 1 decode) and start a
// new message; write it only while the block is idle.
// The word that completes a group is pushed as a job into the queue, and the
// group's first word then moves from the queue head into the output register.
// The input takes one word per cycle while the queue is not full; the rate is
// set by the output register draining the job queue, which gives one word per
// cycle unless stalled; a three-byte encode group yields four characters.
// When the receiver stalls, the output word holds; jobs pile up in the queue
// and din_stall rises once it is full.
// Reset clears the direction to encode, empties the queue and the group.
module base64_codec_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             cfg_we,
	input  wire             cfg_wdata,
	input  b64_pkg::in_t    din,
	input  wire             din_valid,
	output logic            din_stall,
	output b64_pkg::out_t   dout,
	output logic            dout_valid,
	input  wire             dout_stall
);

	logic           accept;
	logic           push;
	logic           pop;
	logic           full;
	logic           empty;
	b64_pkg::job_t  job;
	b64_pkg::job_t  head;

	// stall the sender only while the queue has no room for another job
	assign din_stall = full;
	assign accept    = din_valid && !full;

	b64_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.item      (din),
		.push      (push),
		.job       (job)
	);

	b64_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (job),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	b64_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.dout       (dout),
		.dout_valid (dout_valid),
		.dout_stall (dout_stall)
	);

endmodule
`default_nettype wire
